// ===== design/htfd_pkg.sv =====
// Shared types, constants and the CRC-8 step for the humidity/temperature frame decoder.
// Used by every module of the block; depends on nothing.
`default_nettype none
package htfd_pkg;

    localparam logic [7:0] CrcInit = 8'hFF;
    localparam logic [7:0] CrcPoly = 8'h31;
    localparam logic [7:0] BusyMask = 8'h80;
    localparam logic [7:0] CalMask = 8'h18;

    localparam logic [2:0] IdxNone = 3'd7;
    localparam logic [2:0] IdxFirst = 3'd1;
    localparam logic [2:0] IdxCrc = 3'd6;

    localparam logic [2:0] StOk = 3'd0;
    localparam logic [2:0] StBusy = 3'd1;
    localparam logic [2:0] StNoCal = 3'd2;
    localparam logic [2:0] StCrc = 3'd3;
    localparam logic [2:0] StRange = 3'd4;

    localparam int RawW = 20;
    localparam int HumW = 14;
    localparam int TempW = 15;
    localparam int HumProdW = 34;
    localparam int TempProdW = 35;

    localparam logic [HumProdW-1:0] HumScale = 34'd10000;
    localparam logic [TempProdW-1:0] TempScale = 35'd20000;
    localparam logic [TempProdW-1:0] RoundHalf = 35'd524288;
    localparam logic signed [15:0] TempOffset = 16'sd5000;
    localparam logic signed [15:0] TempMin = -16'sd4000;
    localparam logic signed [15:0] TempMax = 16'sd8000;

    localparam int QDepth = 4;
    localparam int QPtrW = $clog2(QDepth);
    localparam int QCntW = $clog2(QDepth + 1);

    typedef struct packed {
        logic [2:0] code;
        logic [RawW-1:0] hraw;
        logic [RawW-1:0] traw;
    } htfd_rec_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CrcPoly;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== design/htfd_front.sv =====
// Front end: accepts frame bytes, runs the CRC, gathers the raw fields and classifies
// each finished frame into a record for the queue. Depends on htfd_pkg.
`default_nettype none
module htfd_front
    import htfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] data_byte,
    input  wire logic       frame_start,
    output logic            push,
    output htfd_rec_t       push_rec
);

    logic [2:0] idx_reg, idx_next;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] sbyte_reg, sbyte_next;
    logic [RawW-1:0] hraw_reg, hraw_next;
    logic [RawW-1:0] traw_reg, traw_next;

    always_comb
    begin
        idx_next = idx_reg;
        crc_next = crc_reg;
        sbyte_next = sbyte_reg;
        hraw_next = hraw_reg;
        traw_next = traw_reg;
        push = 1'b0;
        if (accept)
        begin
            if (frame_start)
            begin
                crc_next = crc8_step(CrcInit, data_byte);
                sbyte_next = data_byte;
                hraw_next = '0;
                traw_next = '0;
                idx_next = IdxFirst;
            end
            else if (idx_reg != IdxNone && idx_reg != 3'd0)
            begin
                case (idx_reg)
                    3'd1: hraw_next = {data_byte, 12'd0};
                    3'd2: hraw_next = hraw_reg | {8'd0, data_byte, 4'd0};
                    3'd3:
                    begin
                        hraw_next = hraw_reg | {16'd0, data_byte[7:4]};
                        traw_next = {data_byte[3:0], 16'd0};
                    end
                    3'd4: traw_next = traw_reg | {4'd0, data_byte, 8'd0};
                    3'd5: traw_next = traw_reg | {12'd0, data_byte};
                    default: ;
                endcase
                if (idx_reg == IdxCrc)
                begin
                    idx_next = IdxNone;
                    push = 1'b1;
                end
                else
                begin
                    crc_next = crc8_step(crc_reg, data_byte);
                    idx_next = idx_reg + 3'd1;
                end
            end
        end
    end

    always_comb
    begin
        push_rec.hraw = hraw_reg;
        push_rec.traw = traw_reg;
        if ((sbyte_reg & BusyMask) != 8'd0)
            push_rec.code = StBusy;
        else if ((sbyte_reg & CalMask) != CalMask)
            push_rec.code = StNoCal;
        else if (crc_reg != data_byte)
            push_rec.code = StCrc;
        else
            push_rec.code = StOk;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= IdxNone;
            crc_reg <= CrcInit;
            sbyte_reg <= '0;
            hraw_reg <= '0;
            traw_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            crc_reg <= crc_next;
            sbyte_reg <= sbyte_next;
            hraw_reg <= hraw_next;
            traw_reg <= traw_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/htfd_queue.sv =====
// Short first-in first-out queue of frame records between the front end and the back end.
// Depends on htfd_pkg.
`default_nettype none
module htfd_queue
    import htfd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire htfd_rec_t push_rec,
    input  wire logic      pop,
    output htfd_rec_t      pop_rec,
    output logic           full,
    output logic           empty,
    output logic [QCntW-1:0] count
);

    htfd_rec_t mem_reg [QDepth];
    logic [QPtrW-1:0] wptr_reg, wptr_next;
    logic [QPtrW-1:0] rptr_reg, rptr_next;
    logic [QCntW-1:0] cnt_reg, cnt_next;
    logic do_push, do_pop;

    assign full = (cnt_reg == QCntW'(QDepth));
    assign empty = (cnt_reg == '0);
    assign count = cnt_reg;
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign pop_rec = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = do_push ? wptr_reg + QPtrW'(1) : wptr_reg;
        rptr_next = do_pop ? rptr_reg + QPtrW'(1) : rptr_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + QCntW'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - QCntW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/htfd_back.sv =====
// Back end: scales the raw fields by constant multiplies, rounds, checks the range and
// holds the result in an output register. Depends on htfd_pkg.
`default_nettype none
module htfd_back
    import htfd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         rec_valid,
    input  wire htfd_rec_t    rec,
    output logic              rec_pop,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [2:0]        out_status,
    output logic [HumW-1:0]   out_humidity,
    output logic [TempW-1:0]  out_temperature
);

    logic s1_valid_reg, s1_valid_next;
    logic [2:0] s1_code_reg;
    logic [HumProdW-1:0] hprod_reg;
    logic [TempProdW-1:0] tprod_reg;
    logic ov_reg, ov_next;
    logic [2:0] st_reg;
    logic [HumW-1:0] hum_reg;
    logic [TempW-1:0] tmp_reg;

    logic s2_load, s1_load;
    logic [HumProdW-1:0] hsum;
    logic [TempProdW-1:0] tsum;
    logic [TempW-1:0] tunsigned;
    logic signed [15:0] tsigned;
    logic [2:0] st_calc;
    logic [HumW-1:0] hum_calc;
    logic [TempW-1:0] tmp_calc;

    assign s2_load = !ov_reg || out_ready;
    assign s1_load = !s1_valid_reg || s2_load;
    assign rec_pop = rec_valid && s1_load;

    always_comb
    begin
        hsum = hprod_reg + RoundHalf[HumProdW-1:0];
        tsum = tprod_reg + RoundHalf;
        tunsigned = tsum[TempProdW-1:20];
        tsigned = signed'({1'b0, tunsigned}) - TempOffset;
        if (s1_code_reg != StOk)
        begin
            st_calc = s1_code_reg;
            hum_calc = '0;
            tmp_calc = '0;
        end
        else
        begin
            hum_calc = hsum[HumProdW-1:20];
            tmp_calc = tsigned[TempW-1:0];
            st_calc = (tsigned < TempMin || tsigned > TempMax) ? StRange : StOk;
        end
        s1_valid_next = s1_load ? rec_valid : s1_valid_reg;
        ov_next = s2_load ? s1_valid_reg : ov_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rec_pop)
        begin
            s1_code_reg <= rec.code;
            hprod_reg <= {14'd0, rec.hraw} * HumScale;
            tprod_reg <= {15'd0, rec.traw} * TempScale;
        end
        if (s2_load && s1_valid_reg)
        begin
            st_reg <= st_calc;
            hum_reg <= hum_calc;
            tmp_reg <= tmp_calc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            ov_reg <= ov_next;
        end
    end

    assign out_valid = ov_reg;
    assign out_status = st_reg;
    assign out_humidity = hum_reg;
    assign out_temperature = tmp_reg;

endmodule
`default_nettype wire

// ===== design/humidity_temp_frame_decoder.sv =====
// Humidity/temperature sensor frame decoder, top level.
// Depends on htfd_pkg, htfd_front, htfd_queue and htfd_back.
//
// Takes one seven-byte sensor frame a byte per word, byte 0 flagged in tuser, checks its
// CRC-8 and emits one word per complete frame with status, humidity in 0.01 %RH and
// temperature in 0.01 degrees C. One byte is accepted every cycle while the queue is not full;
// once its CRC byte is accepted, a frame's record is written into the queue, then passes through
// the multiply stage into the output register and waits there until it is taken. Input is held
// off only when the four-entry record queue is full.
`default_nettype none
module humidity_temp_frame_decoder
    import htfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] frame_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // [2:0] status, [16:3] humidity, [31:17] temperature
);

    logic accept;
    logic push;
    htfd_rec_t push_rec;
    htfd_rec_t pop_rec;
    logic pop;
    logic q_full, q_empty;
    logic [QCntW-1:0] q_count;
    logic [2:0] status;
    logic [HumW-1:0] humidity;
    logic [TempW-1:0] temperature;

    assign s_axis_tready = !q_full;
    assign accept = s_axis_tvalid && s_axis_tready;

    htfd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (s_axis_tdata),
        .frame_start (s_axis_tuser),
        .push        (push),
        .push_rec    (push_rec)
    );

    htfd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .full     (q_full),
        .empty    (q_empty),
        .count    (q_count)
    );

    htfd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .rec_valid       (!q_empty),
        .rec             (pop_rec),
        .rec_pop         (pop),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_status      (status),
        .out_humidity    (humidity),
        .out_temperature (temperature)
    );

    assign m_axis_tdata = {temperature, humidity, status};

`ifndef SYNTHESIS
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (status <= StRange))
        else $error("result status code out of range");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (status == StBusy || status == StNoCal || status == StCrc)
        |-> (humidity == '0 && temperature == '0))
        else $error("fields not zero on a failed frame");

    a_ok_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && status == StOk
        |-> ($signed(temperature) >= -15'sd4000 && $signed(temperature) <= 15'sd8000
             && humidity <= 14'd10000))
        else $error("ok result outside the valid range");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> (q_count == QCntW'(QDepth) && !s_axis_tready))
        else $error("queue full flag inconsistent with count");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_humidity_temp_frame_decoder.sv =====
// Self-checking testbench for humidity_temp_frame_decoder: sensor frames in, decoded readings out.
// Depends on htfd_pkg and the humidity_temp_frame_decoder RTL; a built-in decoder predicts each word.
`default_nettype none
module tb_humidity_temp_frame_decoder;
    import htfd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ClkPeriod = 4;
    localparam int ResetCycles = 8;
    localparam int RandomBytes = 850;
    localparam int TailBytes = 150;
    localparam int HoldCycles = 200;
    localparam int StallLimit = 5000;
    localparam int DrainCycles = 20;

    localparam longint unsigned HumSpan = 10000;
    localparam longint unsigned TempSpan = 20000;
    localparam longint unsigned HalfLsb = 524288;
    localparam int TempBase = 5000;
    localparam int TempLow = -4000;
    localparam int TempHigh = 8000;

    typedef struct {
        logic [7:0] data;
        logic       start;
    } link_byte_t;

    typedef struct {
        logic [2:0]              status;
        logic [HumW-1:0]         humidity;
        logic signed [TempW-1:0] temperature;
    } reading_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    link_byte_t bytes_to_send[$];
    reading_t   readings_due[$];

    logic [2:0]      byte_pos = IdxNone;
    logic [7:0]      crc_acc = CrcInit;
    logic [7:0]      head_byte = '0;
    logic [RawW-1:0] hum_raw = '0;
    logic [RawW-1:0] tmp_raw = '0;

    bit sender_gaps = 1'b1;
    bit receiver_gaps = 1'b1;
    bit hold_req = 1'b0;
    int send_gap_left = 0;
    int recv_gap_left = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    int mismatches = 0;
    int frame_bytes_queued = 0;
    link_byte_t next_byte;

    humidity_temp_frame_decoder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(ClkPeriod / 2) clk = ~clk;

    function automatic logic [7:0] crc8_0x31(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] acc;
        logic       fb;
        acc = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = acc[7] ^ b[i];
            acc = {acc[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
        end
        return acc;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic start);
        reading_t        reading;
        longint unsigned hum_q;
        longint unsigned tmp_q;
        int              tmp_val;
        if (start)
        begin
            crc_acc = crc8_0x31(CrcInit, b);
            head_byte = b;
            hum_raw = '0;
            tmp_raw = '0;
            byte_pos = IdxFirst;
            return;
        end
        if (byte_pos == IdxNone || byte_pos == 3'd0)
            return;
        case (byte_pos)
            3'd1: hum_raw = {b, 12'h000};
            3'd2: hum_raw[11:4] = b;
            3'd3:
            begin
                hum_raw[3:0] = b[7:4];
                tmp_raw = {b[3:0], 16'h0000};
            end
            3'd4: tmp_raw[15:8] = b;
            3'd5: tmp_raw[7:0] = b;
            default: ;
        endcase
        if (byte_pos < IdxCrc)
        begin
            crc_acc = crc8_0x31(crc_acc, b);
            byte_pos = byte_pos + 3'd1;
            return;
        end
        byte_pos = IdxNone;
        reading.humidity = '0;
        reading.temperature = '0;
        if ((head_byte & BusyMask) != 8'h00)
            reading.status = StBusy;
        else if ((head_byte & CalMask) != CalMask)
            reading.status = StNoCal;
        else if (crc_acc != b)
            reading.status = StCrc;
        else
        begin
            hum_q = hum_raw;
            hum_q = (hum_q * HumSpan + HalfLsb) >> 20;
            tmp_q = tmp_raw;
            tmp_q = (tmp_q * TempSpan + HalfLsb) >> 20;
            tmp_val = int'(tmp_q) - TempBase;
            if (tmp_val < TempLow || tmp_val > TempHigh || hum_q > HumSpan)
                reading.status = StRange;
            else
                reading.status = StOk;
            reading.humidity = hum_q[HumW-1:0];
            reading.temperature = tmp_val[TempW-1:0];
        end
        readings_due.push_back(reading);
    endfunction

    task automatic send_byte(input logic [7:0] data, input logic start);
        link_byte_t item;
        item.data = data;
        item.start = start;
        bytes_to_send.push_back(item);
    endtask

    task automatic queue_frame(input logic [7:0] stat, input logic [RawW-1:0] hraw,
                               input logic [RawW-1:0] traw, input bit bad_crc);
        logic [7:0] frame[7];
        logic [7:0] crc;
        frame[0] = stat;
        frame[1] = hraw[19:12];
        frame[2] = hraw[11:4];
        frame[3] = {hraw[3:0], traw[19:16]};
        frame[4] = traw[15:8];
        frame[5] = traw[7:0];
        crc = CrcInit;
        for (int i = 0; i < 6; i++)
            crc = crc8_0x31(crc, frame[i]);
        frame[6] = bad_crc ? (crc ^ 8'($urandom_range(1, 255))) : crc;
        for (int i = 0; i < 7; i++)
            send_byte(frame[i], i == 0);
        frame_bytes_queued += 7;
    endtask

    task automatic queue_random_frame();
        logic [7:0]      stat;
        logic [RawW-1:0] traw;
        stat = 8'($urandom);
        if ($urandom_range(0, 9) < 8)
            stat = (stat & ~BusyMask) | CalMask;
        if ($urandom_range(0, 1) == 0)
            traw = RawW'($urandom);
        else
            traw = RawW'($urandom_range(52429, 681574));
        queue_frame(stat, RawW'($urandom), traw, $urandom_range(0, 9) == 0);
    endtask

    task automatic wait_for_idle();
        while (bytes_to_send.size() != 0 || s_axis_tvalid || readings_due.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                decode_byte(s_axis_tdata, s_axis_tuser);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap_left > 0)
                begin
                    send_gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (sender_gaps && $urandom_range(0, 7) == 0)
                begin
                    send_gap_left = $urandom_range(0, 2);
                    s_axis_tvalid <= 1'b0;
                end
                else if (bytes_to_send.size() != 0)
                begin
                    next_byte = bytes_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= next_byte.data;
                    s_axis_tuser <= next_byte.start;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (readings_due.size() == 0)
                begin
                    $error("unexpected word: tdata %h", m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = readings_due.pop_front();
                    if (m_axis_tdata[2:0] !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, m_axis_tdata[2:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[16:3] !== want.humidity)
                    begin
                        $error("humidity mismatch: expected %0d, actual %0d",
                               want.humidity, m_axis_tdata[16:3]);
                        mismatches++;
                    end
                    if ($signed(m_axis_tdata[31:17]) !== want.temperature)
                    begin
                        $error("temperature mismatch: expected %0d, actual %0d",
                               want.temperature, $signed(m_axis_tdata[31:17]));
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HoldCycles - 1;
                m_axis_tready <= 1'b0;
            end
            else if (recv_gap_left > 0)
            begin
                recv_gap_left--;
                m_axis_tready <= 1'b0;
            end
            else if (receiver_gaps && $urandom_range(0, 5) == 0)
            begin
                recv_gap_left = $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= StallLimit)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        int pick;
        repeat (ResetCycles) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A stray word with no frame open, then a frame cut short by a new start.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h12, 1'b0);
        queue_frame(8'hFF, 20'hFFFFF, 20'hFFFFF, 1'b0);
        queue_frame(8'h10, RawW'($urandom), RawW'($urandom), 1'b0);
        queue_frame(8'h18, RawW'($urandom), 20'd400000, 1'b1);
        queue_frame(8'h1C, 20'hFFFFF, 20'd681574, 1'b0);
        queue_frame(8'h18, 20'h00000, 20'h00000, 1'b0);
        send_byte(8'hFF, 1'b0);
        wait_for_idle();

        // Back-to-back frames while the output is held off, so the input backs up.
        sender_gaps = 1'b0;
        for (int i = 0; i < 16; i++)
            queue_random_frame();
        hold_req = 1'b1;
        while (bytes_to_send.size() != 0)
            @(negedge clk);
        sender_gaps = 1'b1;

        frame_bytes_queued = 0;
        while (frame_bytes_queued < RandomBytes)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom), 1'b0);
            end
            else
            begin
                if (pick <= 3)
                begin
                    send_byte(8'($urandom), 1'b1);
                    frame_bytes_queued++;
                    repeat ($urandom_range(0, 5))
                    begin
                        send_byte(8'($urandom), 1'b0);
                        frame_bytes_queued++;
                    end
                end
                queue_random_frame();
            end
        end
        while (bytes_to_send.size() > TailBytes)
            @(negedge clk);
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        wait_for_idle();
        repeat (DrainCycles) @(negedge clk);

        if (mismatches == 0 && readings_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
